// ----- rtl/core/emb_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers of the monthly energy bin block
package emb_pkg;

	// history depth and slot index width
	localparam int HIST_MONTHS = 16;
	localparam int HIST_IDX_W  = (HIST_MONTHS > 1) ? $clog2(HIST_MONTHS) : 1;

	// request opcodes
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAX_GAP   = 2'd0,
		CFG_CHECK_MS  = 2'd1,
		CFG_EPOCH_MIN = 2'd2
	} cfg_idx_t;

	// configuration reset values
	localparam logic [15:0] MAX_GAP_RST   = 16'd5000;
	localparam logic [31:0] CHECK_MS_RST  = 32'd60000;
	localparam logic [31:0] EPOCH_MIN_RST = 32'd1700000000;

	// energy kept as quotient and remainder of W*ms over one hour of ms,
	// biased by half an hour so the quotient is already the rounded Wh
	localparam int WH_DIV  = 3600000;
	localparam int WH_HALF = 1800000;
	localparam int REM_W   = 22;
	localparam int QUO_W   = 43;

	// per sample increment: watts magnitude times gap, then split by WH_DIV
	localparam int GAP_W       = 16;
	localparam int WMAG_W      = 15;
	localparam int PROD_W      = GAP_W + WMAG_W;
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 42;
	localparam int PM_W        = PROD_W + RECIP_W;
	localparam int INC_Q_W     = PM_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP = 21'd1221679;

	// biased saturation point of a 64-bit W*ms accumulator
	localparam logic [QUO_W-1:0] E_Q_MAX = 43'd5124095576030;
	localparam logic [REM_W-1:0] E_R_MAX = 22'd3351615;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [15:0] max_gap;
		logic [31:0] check_ms;
		logic [31:0] epoch_min;
	} emb_cfg_t;

	typedef struct packed {
		op_t         op;
		logic        integ;
		logic        due;
		logic        synced;
		logic [31:0] epoch;
		logic [11:0] year;
		logic [3:0]  month;
		logic [3:0]  slot;
	} item_ctl_t;

	typedef struct packed {
		item_ctl_t          ctl;
		logic [INC_Q_W-1:0] inc_q;
		logic [REM_W-1:0]   inc_r;
	} emb_item_t;

	typedef struct packed {
		logic [QUO_W-1:0] q;
		logic [REM_W-1:0] r;
	} acc_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [31:0] wh;
	} hist_ent_t;

	localparam acc_t ACC_EMPTY = '{q: '0, r: REM_W'(WH_HALF)};
	localparam acc_t ACC_MAX   = '{q: E_Q_MAX, r: E_R_MAX};

	// rounded quotient to 32-bit Wh, saturating
	function automatic logic [31:0] sat_wh(input logic [QUO_W-1:0] q);
		return (|q[QUO_W-1:32]) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

endpackage

// ----- rtl/core/emb_front.sv -----
`timescale 1ns / 1ps
// front end: accepts requests, classifies samples, computes the Wh increment
module emb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] watts,
	input  logic [31:0]        epoch_s,
	input  logic [11:0]        year,
	input  logic [3:0]         month,
	input  logic [3:0]         slot,
	input  emb_pkg::emb_cfg_t  cfg,
	input  logic               q_full,
	output logic               q_push,
	output emb_pkg::emb_item_t q_item
);

	localparam int GapW  = emb_pkg::GAP_W;
	localparam int WmagW = emb_pkg::WMAG_W;
	localparam int ProdW = emb_pkg::PROD_W;
	localparam int PmW   = emb_pkg::PM_W;
	localparam int IncQW = emb_pkg::INC_Q_W;
	localparam int RemW  = emb_pkg::REM_W;

	logic [31:0] last_sample_q;
	logic [31:0] last_check_q;

	logic [31:0] gap;
	logic [31:0] since_check;
	logic        sample_op;
	logic        w_pos;
	logic        integ;
	logic        due;
	logic        accept;
	logic        free1, free2, free3;
	logic        adv1, adv2, adv3;
	emb_pkg::item_ctl_t ctl_in;

	logic                 v_s1, v_s2, v_s3;
	emb_pkg::item_ctl_t   ctl_s1, ctl_s2, ctl_s3;
	logic [GapW-1:0]      gap_s1;
	logic [WmagW-1:0]     wmag_s1;
	logic [ProdW-1:0]     prod_s2, prod_s3;
	logic [IncQW-1:0]     qest_s3;

	logic [PmW-1:0]       prod_m;
	logic [31:0]          r_est;
	logic                 r_over;

	// sample classification against the last sample and last check times
	always_comb begin
		sample_op   = (emb_pkg::op_t'(op) == emb_pkg::OP_SAMPLE);
		gap         = now_ms - last_sample_q;
		since_check = now_ms - last_check_q;
		w_pos       = !watts[15] && (watts != '0);
		integ       = sample_op && (last_sample_q != '0) && (gap != '0)
			&& (gap <= {16'd0, cfg.max_gap}) && w_pos;
		due         = (since_check >= cfg.check_ms);
	end

	always_comb begin
		ctl_in.op     = emb_pkg::op_t'(op);
		ctl_in.integ  = integ;
		ctl_in.due    = due;
		ctl_in.synced = (epoch_s > cfg.epoch_min);
		ctl_in.epoch  = epoch_s;
		ctl_in.year   = year;
		ctl_in.month  = month;
		ctl_in.slot   = slot;
	end

	// stage advance chain, backed up by the queue
	always_comb begin
		free3    = !v_s3 || !q_full;
		adv3     = v_s3 && !q_full;
		free2    = !v_s2 || free3;
		adv2     = v_s2 && free3;
		free1    = !v_s1 || free2;
		adv1     = v_s1 && free2;
		in_stall = !free1;
		accept   = in_valid && free1;
	end

	// sample and check timestamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			last_check_q  <= '0;
		end else if (accept && sample_op) begin
			last_sample_q <= now_ms;
			if (integ && due) begin
				last_check_q <= now_ms;
			end
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
		end
	end

	// reciprocal estimate of the hour quotient
	always_comb begin
		prod_m = PmW'(prod_s2) * PmW'(emb_pkg::RECIP);
	end

	// stage payloads: classify, multiply, quotient estimate
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl_in;
			gap_s1  <= gap[GapW-1:0];
			wmag_s1 <= watts[WmagW-1:0];
		end
		if (adv1) begin
			ctl_s2  <= ctl_s1;
			prod_s2 <= ProdW'(gap_s1) * ProdW'(wmag_s1);
		end
		if (adv2) begin
			ctl_s3  <= ctl_s2;
			prod_s3 <= prod_s2;
			qest_s3 <= prod_m[emb_pkg::RECIP_SHIFT +: IncQW];
		end
	end

	// remainder and one step of correction
	always_comb begin
		r_est  = 32'(prod_s3) - (32'(qest_s3) * 32'(emb_pkg::WH_DIV));
		r_over = (r_est >= 32'(emb_pkg::WH_DIV));
		q_push       = adv3;
		q_item.ctl   = ctl_s3;
		q_item.inc_q = r_over ? (qest_s3 + IncQW'(1)) : qest_s3;
		q_item.inc_r = r_over ? RemW'(r_est - 32'(emb_pkg::WH_DIV)) : RemW'(r_est);
	end

endmodule

// ----- rtl/core/emb_queue.sv -----
`timescale 1ns / 1ps
// short request queue between front end and back end
module emb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  emb_pkg::emb_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output emb_pkg::emb_item_t pop_item
);

	localparam int Depth = emb_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	emb_pkg::emb_item_t items_q [Depth];
	logic [PtrW-1:0]    wr_q;
	logic [PtrW-1:0]    rd_q;
	logic [CntW-1:0]    cnt_q;

	// status
	always_comb begin
		full      = (cnt_q == CntW'(Depth));
		not_empty = (cnt_q != '0);
		pop_item  = items_q[rd_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			items_q[wr_q] <= push_item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

// ----- rtl/core/emb_back.sv -----
`timescale 1ns / 1ps
// back end: accumulators, month tracking, history and the result register
module emb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  emb_pkg::emb_item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        current_wh,
	output logic [31:0]        lifetime_wh,
	output logic [31:0]        start_epoch,
	output logic [11:0]        cur_year,
	output logic [3:0]         cur_month,
	output logic               rolled_over,
	output logic [11:0]        hist_year,
	output logic [3:0]         hist_month,
	output logic [31:0]        hist_wh
);

	localparam int Hist  = emb_pkg::HIST_MONTHS;
	localparam int IdxW  = emb_pkg::HIST_IDX_W;
	localparam int RemW  = emb_pkg::REM_W;
	localparam int QuoW  = emb_pkg::QUO_W;
	localparam int RsW   = RemW + 1;
	localparam int IncQW = emb_pkg::INC_Q_W;

	// add an increment to a biased quotient/remainder pair, saturating
	function automatic emb_pkg::acc_t acc_add(
		input emb_pkg::acc_t     a,
		input logic [IncQW-1:0]  iq,
		input logic [RemW-1:0]   ir
	);
		logic [RsW-1:0] r_sum;
		logic           carry;
		emb_pkg::acc_t  s;
		r_sum = {1'b0, a.r} + {1'b0, ir};
		carry = (r_sum >= RsW'(emb_pkg::WH_DIV));
		s.r   = carry ? RemW'(r_sum - RsW'(emb_pkg::WH_DIV)) : RemW'(r_sum);
		s.q   = a.q + QuoW'(iq) + QuoW'(carry);
		if ((s.q > emb_pkg::E_Q_MAX) || ((s.q == emb_pkg::E_Q_MAX) && (s.r > emb_pkg::E_R_MAX))) begin
			s = emb_pkg::ACC_MAX;
		end
		return s;
	endfunction

	emb_pkg::acc_t      mon_q, life_q;
	logic [31:0]        first_q;
	logic [11:0]        ty_q;
	logic [3:0]         tm_q;
	emb_pkg::hist_ent_t hist_q [Hist];

	emb_pkg::acc_t      mon_d, life_d, mon_sum;
	logic [31:0]        first_d;
	logic [11:0]        ty_d;
	logic [3:0]         tm_d;
	emb_pkg::hist_ent_t hist_d [Hist];
	emb_pkg::hist_ent_t hrd;
	logic               rolled_d;
	logic               take;
	emb_pkg::item_ctl_t c;

	logic        out_v_q;
	logic [31:0] cur_wh_q, life_wh_q, start_q;
	logic [11:0] cy_q, hy_q;
	logic [3:0]  cm_q, hm_q;
	logic        rolled_q;
	logic [31:0] hw_q;

	// take a queued request when the result register is free
	always_comb begin
		take  = q_valid && (!out_v_q || !out_stall);
		q_pop = take;
		c     = q_item.ctl;
	end

	// execute one request
	always_comb begin
		mon_d    = mon_q;
		life_d   = life_q;
		first_d  = first_q;
		ty_d     = ty_q;
		tm_d     = tm_q;
		hist_d   = hist_q;
		hrd      = '0;
		rolled_d = 1'b0;
		mon_sum  = acc_add(mon_q, q_item.inc_q, q_item.inc_r);
		if (take) begin
			case (c.op)
				emb_pkg::OP_SAMPLE: begin
					if (c.integ) begin
						mon_d  = mon_sum;
						life_d = acc_add(life_q, q_item.inc_q, q_item.inc_r);
						if ((first_q == '0) && c.synced) begin
							first_d = c.epoch;
						end
						if (c.due && c.synced) begin
							if (ty_q == '0) begin
								ty_d = c.year;
								tm_d = c.month;
							end else if ((c.year != ty_q) || (c.month != tm_q)) begin
								for (int i = 0; i < Hist - 1; i++) begin
									hist_d[i] = hist_q[i + 1];
								end
								hist_d[Hist-1].year  = ty_q;
								hist_d[Hist-1].month = tm_q;
								hist_d[Hist-1].wh    = emb_pkg::sat_wh(mon_sum.q);
								mon_d    = emb_pkg::ACC_EMPTY;
								ty_d     = c.year;
								tm_d     = c.month;
								rolled_d = 1'b1;
							end
						end
					end
				end
				emb_pkg::OP_CLEAR: begin
					mon_d   = emb_pkg::ACC_EMPTY;
					life_d  = emb_pkg::ACC_EMPTY;
					first_d = '0;
					ty_d    = '0;
					tm_d    = '0;
					for (int i = 0; i < Hist; i++) begin
						hist_d[i] = '0;
					end
				end
				emb_pkg::OP_READ: begin
					if (32'(c.slot) < 32'(Hist)) begin
						hrd = hist_q[IdxW'(c.slot)];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mon_q   <= emb_pkg::ACC_EMPTY;
			life_q  <= emb_pkg::ACC_EMPTY;
			first_q <= '0;
			ty_q    <= '0;
			tm_q    <= '0;
			for (int i = 0; i < Hist; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			mon_q   <= mon_d;
			life_q  <= life_d;
			first_q <= first_d;
			ty_q    <= ty_d;
			tm_q    <= tm_d;
			hist_q  <= hist_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			cur_wh_q  <= emb_pkg::sat_wh(mon_d.q);
			life_wh_q <= emb_pkg::sat_wh(life_d.q);
			start_q   <= first_d;
			cy_q      <= ty_d;
			cm_q      <= tm_d;
			rolled_q  <= rolled_d;
			hy_q      <= hrd.year;
			hm_q      <= hrd.month;
			hw_q      <= hrd.wh;
		end
	end

	assign out_valid   = out_v_q;
	assign current_wh  = cur_wh_q;
	assign lifetime_wh = life_wh_q;
	assign start_epoch = start_q;
	assign cur_year    = cy_q;
	assign cur_month   = cm_q;
	assign rolled_over = rolled_q;
	assign hist_year   = hy_q;
	assign hist_month  = hm_q;
	assign hist_wh     = hw_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mon_q.r < RemW'(emb_pkg::WH_DIV)) && (life_q.r < RemW'(emb_pkg::WH_DIV)))
		else $error("accumulator remainder out of range");

	a_life_ge_month: assert property (@(posedge clk) disable iff (!arst_n)
		{life_q.q, life_q.r} >= {mon_q.q, mon_q.r})
		else $error("lifetime energy below month energy");

	a_roll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && rolled_q) |-> (cur_wh_q == '0))
		else $error("month total not cleared on rollover");

endmodule

// ----- rtl/core/energy_meter_monthly_bins.sv -----
`timescale 1ns / 1ps
// top level of the power sample energy integrator with monthly history bins
//
//   channel   handshake              payload
//   input     in_valid / in_stall    op, now_ms, watts, epoch_s, year, month, slot
//   result    out_valid / out_stall  current_wh .. hist_wh, one per request
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per clock sustained while out_stall stays low; a taken request passes
// through the three front stages, the queue and the result register before its result shows
// reset clears all energy, dates and history and loads the configuration defaults
// out_stall holds the result; the front keeps taking requests until its three
// stages and the four-entry queue are full, then raises in_stall
// cfg_ready is always high
module energy_meter_monthly_bins (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] watts,
	input  logic [31:0]        epoch_s,
	input  logic [11:0]        year,
	input  logic [3:0]         month,
	input  logic [3:0]         slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        current_wh,
	output logic [31:0]        lifetime_wh,
	output logic [31:0]        start_epoch,
	output logic [11:0]        cur_year,
	output logic [3:0]         cur_month,
	output logic               rolled_over,
	output logic [11:0]        hist_year,
	output logic [3:0]         hist_month,
	output logic [31:0]        hist_wh,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	emb_pkg::emb_cfg_t  cfg_q;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_valid;
	emb_pkg::emb_item_t push_item;
	emb_pkg::emb_item_t pop_item;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_gap   <= emb_pkg::MAX_GAP_RST;
			cfg_q.check_ms  <= emb_pkg::CHECK_MS_RST;
			cfg_q.epoch_min <= emb_pkg::EPOCH_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (emb_pkg::cfg_idx_t'(cfg_index))
				emb_pkg::CFG_MAX_GAP:   cfg_q.max_gap   <= cfg_data[15:0];
				emb_pkg::CFG_CHECK_MS:  cfg_q.check_ms  <= cfg_data;
				emb_pkg::CFG_EPOCH_MIN: cfg_q.epoch_min <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request intake and increment arithmetic
	emb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.now_ms   (now_ms),
		.watts    (watts),
		.epoch_s  (epoch_s),
		.year     (year),
		.month    (month),
		.slot     (slot),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	// decoupling queue
	emb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_item  (pop_item)
	);

	// execution and results
	emb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.current_wh  (current_wh),
		.lifetime_wh (lifetime_wh),
		.start_epoch (start_epoch),
		.cur_year    (cur_year),
		.cur_month   (cur_month),
		.rolled_over (rolled_over),
		.hist_year   (hist_year),
		.hist_month  (hist_month),
		.hist_wh     (hist_wh)
	);

endmodule

// ----- tb/emb_tb_pkg.sv -----
`timescale 1ns / 1ps
// status type and scoreboard for the monthly energy bin testbench
package emb_tb_pkg;
	import emb_pkg::*;

	// milliseconds in one hour and in half an hour
	localparam logic [63:0] MS_IN_HOUR      = 64'd3600000;
	localparam logic [63:0] MS_IN_HALF_HOUR = 64'd1800000;

	// one result of the block
	typedef struct packed {
		logic [31:0] current_wh;
		logic [31:0] lifetime_wh;
		logic [31:0] start_epoch;
		logic [11:0] cur_year;
		logic [3:0]  cur_month;
		logic        rolled_over;
		logic [11:0] hist_year;
		logic [3:0]  hist_month;
		logic [31:0] hist_wh;
	} meter_status_t;

	class meter_scoreboard;
		int unsigned   errors;
		meter_status_t expected_status[$];

		// register copies
		bit [15:0] max_gap;
		bit [31:0] check_ms;
		bit [31:0] epoch_min;

		// predicted energy, dates and history
		bit [31:0] last_sample;
		bit [31:0] last_check;
		bit [31:0] first_epoch;
		bit [63:0] month_e;
		bit [63:0] life_e;
		bit [11:0] trk_year;
		bit [3:0]  trk_month;
		bit [11:0] slot_year[HIST_MONTHS];
		bit [3:0]  slot_month[HIST_MONTHS];
		bit [31:0] slot_wh[HIST_MONTHS];

		function new();
			errors      = 0;
			max_gap     = 16'd5000;
			check_ms    = 32'd60000;
			epoch_min   = 32'd1700000000;
			last_sample = '0;
			last_check  = '0;
			clear_all();
		endfunction

		function int unsigned pending();
			return expected_status.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100) begin
				$display("MISMATCH: %s", msg);
			end
		endtask

		function void load_register(logic [1:0] idx, logic [31:0] data);
			case (cfg_idx_t'(idx))
				CFG_MAX_GAP:   max_gap = data[15:0];
				CFG_CHECK_MS:  check_ms = data;
				CFG_EPOCH_MIN: epoch_min = data;
				default: ;
			endcase
		endfunction

		// W*ms to watt-hours, half up, saturating at 32 bits
		function bit [31:0] round_wh(bit [63:0] e);
			bit [63:0] q;
			q = e / MS_IN_HOUR;
			if (e % MS_IN_HOUR >= MS_IN_HALF_HOUR) begin
				q++;
			end
			return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		endfunction

		function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
			bit [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? {64{1'b1}} : s[63:0];
		endfunction

		function void clear_all();
			month_e     = '0;
			life_e      = '0;
			first_epoch = '0;
			trk_year    = '0;
			trk_month   = '0;
			for (int i = 0; i < HIST_MONTHS; i++) begin
				slot_year[i]  = '0;
				slot_month[i] = '0;
				slot_wh[i]    = '0;
			end
		endfunction

		// shift the history down and put the closed month in the newest slot
		function void close_month();
			for (int i = 0; i < HIST_MONTHS - 1; i++) begin
				slot_year[i]  = slot_year[i+1];
				slot_month[i] = slot_month[i+1];
				slot_wh[i]    = slot_wh[i+1];
			end
			slot_year[HIST_MONTHS-1]  = trk_year;
			slot_month[HIST_MONTHS-1] = trk_month;
			slot_wh[HIST_MONTHS-1]    = round_wh(month_e);
		endfunction

		// integrate one power sample, returns 1 when a month was closed
		function bit integrate_sample(bit [31:0] t, logic signed [15:0] w, bit [31:0] ep,
				bit [11:0] y, bit [3:0] m);
			bit [31:0] gap;
			bit [31:0] since_check;
			bit [63:0] inc;
			if (last_sample == 0) begin
				last_sample = t;
				return 1'b0;
			end
			gap = t - last_sample;
			last_sample = t;
			if (gap == 0 || gap > {16'd0, max_gap} || w <= 16'sd0) begin
				return 1'b0;
			end
			inc     = {48'd0, w} * {32'd0, gap};
			month_e = sat_add(month_e, inc);
			life_e  = sat_add(life_e, inc);
			if (first_epoch == 0 && ep > epoch_min) begin
				first_epoch = ep;
			end
			since_check = t - last_check;
			if (since_check >= check_ms) begin
				last_check = t;
				if (ep > epoch_min) begin
					if (trk_year == 0) begin
						trk_year  = y;
						trk_month = m;
					end else if (y != trk_year || m != trk_month) begin
						close_month();
						month_e   = '0;
						trk_year  = y;
						trk_month = m;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		// predict the result of an accepted request
		function void note_request(logic [1:0] o, logic [31:0] t, logic signed [15:0] w,
				logic [31:0] ep, logic [11:0] y, logic [3:0] m, logic [3:0] s);
			meter_status_t st;
			st = '0;
			case (op_t'(o))
				OP_SAMPLE: st.rolled_over = integrate_sample(t, w, ep, y, m);
				OP_CLEAR:  clear_all();
				OP_READ: begin
					if (s < HIST_MONTHS) begin
						st.hist_year  = slot_year[s];
						st.hist_month = slot_month[s];
						st.hist_wh    = slot_wh[s];
					end
				end
				default: ;
			endcase
			st.current_wh  = round_wh(month_e);
			st.lifetime_wh = round_wh(life_e);
			st.start_epoch = first_epoch;
			st.cur_year    = trk_year;
			st.cur_month   = trk_month;
			expected_status.push_back(st);
		endfunction

		// compare a result with the oldest prediction
		task check_result(meter_status_t got);
			meter_status_t want;
			if (expected_status.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = expected_status.pop_front();
			if (got.current_wh !== want.current_wh)
				report($sformatf("current_wh %0d, expected %0d", got.current_wh,
					want.current_wh));
			if (got.lifetime_wh !== want.lifetime_wh)
				report($sformatf("lifetime_wh %0d, expected %0d", got.lifetime_wh,
					want.lifetime_wh));
			if (got.start_epoch !== want.start_epoch)
				report($sformatf("start_epoch %0d, expected %0d", got.start_epoch,
					want.start_epoch));
			if (got.cur_year !== want.cur_year)
				report($sformatf("cur_year %0d, expected %0d", got.cur_year, want.cur_year));
			if (got.cur_month !== want.cur_month)
				report($sformatf("cur_month %0d, expected %0d", got.cur_month,
					want.cur_month));
			if (got.rolled_over !== want.rolled_over)
				report($sformatf("rolled_over %0d, expected %0d", got.rolled_over,
					want.rolled_over));
			if (got.hist_year !== want.hist_year)
				report($sformatf("hist_year %0d, expected %0d", got.hist_year,
					want.hist_year));
			if (got.hist_month !== want.hist_month)
				report($sformatf("hist_month %0d, expected %0d", got.hist_month,
					want.hist_month));
			if (got.hist_wh !== want.hist_wh)
				report($sformatf("hist_wh %0d, expected %0d", got.hist_wh, want.hist_wh));
		endtask
	endclass

endpackage

// ----- tb/energy_meter_monthly_bins_test.sv -----
`timescale 1ns / 1ps
// testbench top: drives requests and configuration, checks every result against a predictor
module energy_meter_monthly_bins_test;
	import emb_pkg::*;
	import emb_tb_pkg::*;

	localparam int          PHASES       = 6;
	localparam int          PHASE_ITEMS  = 190;
	localparam int          QUIET_LIMIT  = 3000;
	localparam logic [31:0] EP_MIN       = 32'd1700000000;
	localparam logic [31:0] EP_SYNC      = 32'd1700000001;

	// register settings of the random phases, extremes included
	localparam logic [15:0] PHASE_GAP[PHASES]   = '{16'd65535, 16'd1, 16'd2000, 16'd65535,
		16'd300, 16'd5000};
	localparam logic [31:0] PHASE_CHECK[PHASES] = '{32'd0, 32'd1, 32'd500, 32'hFFFF_FFFF,
		32'd7, 32'd60000};
	localparam logic [31:0] PHASE_EPOCH[PHASES] = '{32'd0, 32'hFFFF_FFFF, 32'd1700000000,
		32'd100, 32'd1000000, 32'd1700000000};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic [31:0]        now_ms;
	logic signed [15:0] watts;
	logic [31:0]        epoch_s;
	logic [11:0]        year;
	logic [3:0]         month;
	logic [3:0]         slot;
	logic               out_valid;
	logic               out_stall;
	logic [31:0]        current_wh;
	logic [31:0]        lifetime_wh;
	logic [31:0]        start_epoch;
	logic [11:0]        cur_year;
	logic [3:0]         cur_month;
	logic               rolled_over;
	logic [11:0]        hist_year;
	logic [3:0]         hist_month;
	logic [31:0]        hist_wh;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	meter_scoreboard sb = new();

	// stimulus side view of time, calendar and settings
	bit [31:0]   clk_ms;
	bit [11:0]   cal_year;
	bit [3:0]    cal_month;
	bit [15:0]   gap_max_now;
	bit [31:0]   epoch_min_now;
	int unsigned quiet_cycles;

	energy_meter_monthly_bins i_dut (.*);

	always #10 clk = ~clk;

	// request, result and register write monitor
	always @(posedge clk) begin : monitor
		meter_status_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{current_wh, lifetime_wh, start_epoch, cur_year, cur_month,
					rolled_over, hist_year, hist_month, hist_wh};
				sb.check_result(got);
			end
			if (in_valid && !in_stall) begin
				sb.note_request(op, now_ms, watts, epoch_s, year, month, slot);
			end
			if (cfg_valid && cfg_ready) begin
				sb.load_register(cfg_index, cfg_data);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// gap lengths: mostly none or short, a few long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// result side back-pressure with stall-free stretches
	initial begin
		out_stall <= 1'b0;
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				repeat ($urandom_range(30, 120)) @(posedge clk);
			end else begin
				repeat (idle_len() + 1) @(posedge clk);
			end
			if ($urandom_range(0, 7) != 0) begin
				out_stall <= 1'b1;
				repeat (idle_len() + 1) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one request, held until taken; valid stays high afterwards
	task automatic send_req(input op_t o, input logic [31:0] t, input logic signed [15:0] w,
			input logic [31:0] ep, input logic [11:0] y, input logic [3:0] m,
			input logic [3:0] s, input int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		now_ms   <= t;
		watts    <= w;
		epoch_s  <= ep;
		year     <= y;
		month    <= m;
		slot     <= s;
		do @(posedge clk); while (in_stall);
	endtask

	// stop requesting and wait for every predicted result
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input bit [15:0] g, input bit [31:0] c, input bit [31:0] e);
		write_register(CFG_MAX_GAP, {16'd0, g});
		write_register(CFG_CHECK_MS, c);
		write_register(CFG_EPOCH_MIN, e);
		cfg_valid     <= 1'b0;
		gap_max_now   = g;
		epoch_min_now = e;
	endtask

	// mostly well-spaced samples of a running calendar, some noise
	task automatic send_random(input int unsigned gap);
		int unsigned        r;
		op_t                o;
		bit [31:0]          ep;
		logic signed [15:0] w;
		bit [11:0]          y;
		bit [3:0]           m;
		r = $urandom_range(0, 99);
		if (r < 87) o = OP_SAMPLE;
		else if (r < 97) o = OP_READ;
		else if (r < 98) o = OP_CLEAR;
		else o = OP_NOP;

		// time step: in range, 1 to 1000 ms, too long or a jump
		r = $urandom_range(0, 99);
		if (r < 80) clk_ms += $urandom_range(1, gap_max_now);
		else if (r < 95) clk_ms += gap_max_now + $urandom_range(1, 1000);
		else clk_ms += $urandom;
		if (r >= 80 && r < 87) clk_ms -= gap_max_now;
		if ($urandom_range(0, 199) == 0) clk_ms = '0;

		r = $urandom_range(0, 99);
		if (r < 80) w = 16'($urandom_range(1, 32767));
		else if (r < 93) w = 16'($urandom);
		else w = '0;

		// calendar moves on now and then, odd dates once in a while
		r = $urandom_range(0, 99);
		if (r < 12) begin
			if (cal_month >= 4'd12) begin
				cal_month = 4'd1;
				cal_year++;
			end else begin
				cal_month++;
			end
		end
		y = cal_year;
		m = cal_month;
		if (r >= 95 && r < 98) begin
			y = 12'($urandom);
			m = 4'($urandom);
		end else if (r >= 98) begin
			y = '0;
		end

		if ($urandom_range(0, 99) < 85 && epoch_min_now != 32'hFFFF_FFFF)
			ep = epoch_min_now + 1 + ($urandom % (32'hFFFF_FFFF - epoch_min_now));
		else
			ep = $urandom;

		send_req(o, clk_ms, w, ep, y, m, 4'($urandom), gap);
	endtask

	initial begin
		bit burst;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		op        <= '0;
		now_ms    <= '0;
		watts     <= '0;
		epoch_s   <= '0;
		year      <= '0;
		month     <= '0;
		slot      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		clk_ms        = 32'd500;
		cal_year      = 12'd2023;
		cal_month     = 4'd11;
		gap_max_now   = 16'd5000;
		epoch_min_now = EP_MIN;
		burst         = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, first samples, skipped gaps and powers
		send_req(OP_READ, 32'd0, 16'sd0, 32'd0, 12'd0, 4'd0, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd0, 16'sd100, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd1000, 16'sd100, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd2000, 16'sd32767, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd7000, 16'h8000, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd12001, 16'sd500, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd12001, 16'sd500, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd17001, 16'sd0, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd22001, 16'sd32767, EP_SYNC, 12'd2024, 4'd1, 4'd0, idle_len());
		send_req(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 4'hF, 0);

		// zero check interval: odd dates and rollovers
		drain_results();
		configure(16'd5000, 32'd0, EP_MIN);
		send_req(OP_SAMPLE, 32'd23000, 16'sd1000, EP_SYNC, 12'd0, 4'd5, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd24000, 16'sd1000, EP_SYNC, 12'd2024, 4'd13, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd25000, 16'sd3000, EP_SYNC, 12'd2024, 4'd14, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd26000, 16'sd32767, EP_SYNC, 12'hFFF, 4'hF, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd27000, 16'sd32767, EP_SYNC, 12'hFFF, 4'hF, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd28000, 16'sd32767, EP_MIN, 12'd2025, 4'd2, 4'd0, idle_len());
		send_req(OP_READ, 32'd0, 16'sd0, 32'd0, 12'd0, 4'd0, 4'd15, idle_len());
		send_req(OP_READ, 32'd0, 16'sd0, 32'd0, 12'd0, 4'd0, 4'd14, idle_len());
		send_req(OP_READ, 32'd0, 16'sd0, 32'd0, 12'd0, 4'd0, 4'd0, idle_len());
		send_req(OP_CLEAR, 32'd0, 16'sd0, 32'd0, 12'd0, 4'd0, 4'd0, idle_len());
		send_req(OP_READ, 32'd0, 16'sd0, 32'd0, 12'd0, 4'd0, 4'd15, idle_len());

		// time wrap, then a sample at time zero restarts the sequence
		send_req(OP_SAMPLE, 32'hFFFF_FFF0, 16'sd200, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 4'd0,
			idle_len());
		send_req(OP_SAMPLE, 32'h0000_0010, 16'sd200, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 4'd0,
			idle_len());
		send_req(OP_SAMPLE, 32'd0, 16'sd200, EP_SYNC, 12'd2024, 4'd3, 4'd0, idle_len());
		send_req(OP_SAMPLE, 32'd500, 16'sd200, EP_SYNC, 12'd2024, 4'd3, 4'd0, idle_len());

		// random phases, one register setting each
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			configure(PHASE_GAP[p], PHASE_CHECK[p], PHASE_EPOCH[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
				send_random(burst ? 0 : idle_len());
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
